/* hdl/uartx_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package uartx_pkg;

    localparam int unsigned MAX_WORD_BITS = 9;
    localparam int unsigned MIN_WORD_BITS = 5;
    localparam int unsigned PERIOD_W      = 16;
    localparam int unsigned WLEN_W        = 4;
    localparam int unsigned CFG_DATA_W    = 16;
    localparam int unsigned CFG_ADDR_W    = 2;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_ADDR_W-1:0] REG_BIT_PERIOD    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WORD_LENGTH   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TWO_STOP_BITS = 2'd2;

    localparam logic [PERIOD_W-1:0] BIT_PERIOD_RST    = 16'd7500;
    localparam logic [WLEN_W-1:0]   WORD_LENGTH_RST   = 4'd8;
    localparam logic                TWO_STOP_BITS_RST = 1'b0;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_OFFER = 1'b1;

    typedef enum logic {
        OP_TICK,
        OP_OFFER
    } op_kind_t;

    typedef struct packed {
        logic                     cmd;
        logic [MAX_WORD_BITS-1:0] word;
    } in_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic refused;
    } out_t;

    typedef struct packed {
        op_kind_t                 kind;
        logic [MAX_WORD_BITS-1:0] word;
    } op_t;

endpackage

`default_nettype wire

/* hdl/uart_serial_transmitter_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Port group   Direction  Handshake            Payload
// s_*          in         s_valid / s_ready    in_t  {cmd, word}
// m_*          out        m_valid / m_ready    out_t {line_level, busy_res, refused}
// cfg_*        in         cfg_we, no wait      cfg_addr, cfg_wdata
//
// One transfer per cycle sustained while m_ready stays high; each result passes through
// the front register, the op queue and the result register.
// Synchronous active-low reset; the line reads idle high after it.
// Front and back stall independently through a two-entry op queue.

module uart_serial_transmitter_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [uartx_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [uartx_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire uartx_pkg::in_t                    s_payload,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output uartx_pkg::out_t                        m_payload
);
    import uartx_pkg::*;

    logic              f_valid;
    logic              f_ready;
    op_t               f_op;
    logic              q_valid;
    logic              q_ready;
    op_t               q_op;
    logic [QCNT_W-1:0] q_level;

    uartx_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_item  (s_payload),
        .op_valid (f_valid),
        .op_ready (f_ready),
        .op       (f_op)
    );

    uartx_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_op     (f_op),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_op    (q_op),
        .level     (q_level)
    );

    uartx_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .op_valid  (q_valid),
        .op_ready  (q_ready),
        .op        (q_op),
        .res_valid (m_valid),
        .res_ready (m_ready),
        .res       (m_payload)
    );

    a_refused_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.refused) |-> m_payload.busy_res)
        else $error("refused result while not busy");

    a_low_line_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_payload.line_level) |-> m_payload.busy_res)
        else $error("line low while idle");

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_level <= QCNT_W'(QUEUE_DEPTH))
        else $error("op queue overflow");

    a_front_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (f_valid && !f_ready) |=> (f_valid && $stable(f_op)))
        else $error("front op lost while queue full");

endmodule

`default_nettype wire

/* hdl/uartx_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module uartx_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire uartx_pkg::in_t in_item,
    output logic                op_valid,
    input  wire logic           op_ready,
    output uartx_pkg::op_t      op
);
    import uartx_pkg::*;

    logic valid_reg;
    op_t  op_reg;
    op_t  op_next;

    assign in_ready = !valid_reg || op_ready;
    assign op_valid = valid_reg;
    assign op       = op_reg;

    always_comb begin
        op_next = op_reg;
        unique case (in_item.cmd)
            CMD_OFFER: begin
                op_next.kind = OP_OFFER;
                op_next.word = in_item.word;
            end
            CMD_TICK: begin
                op_next.kind = OP_TICK;
                op_next.word = '0;
            end
            default: begin
                op_next.kind = OP_TICK;
                op_next.word = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            op_reg <= op_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/uartx_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module uartx_queue (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire uartx_pkg::op_t          in_op,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output uartx_pkg::op_t               out_op,
    output logic [uartx_pkg::QCNT_W-1:0] level
);
    import uartx_pkg::*;

    op_t                mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               push;
    logic               pop;

    assign in_ready  = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_op    = mem_reg[rd_ptr_reg];
    assign level     = count_reg;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                            : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                            : rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_op;
        end
    end

endmodule

`default_nettype wire

/* hdl/uartx_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module uartx_back (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_we,
    input  wire logic [uartx_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [uartx_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                        op_valid,
    output logic                             op_ready,
    input  wire uartx_pkg::op_t              op,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output uartx_pkg::out_t                  res
);
    import uartx_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_START,
        PH_DATA,
        PH_STOP
    } phase_t;

    logic [PERIOD_W-1:0]      bit_period_reg;
    logic [WLEN_W-1:0]        word_length_reg;
    logic                     two_stop_reg;

    phase_t                   phase_reg,  phase_next;
    logic [MAX_WORD_BITS-1:0] shift_reg,  shift_next;
    logic [WLEN_W-1:0]        bits_reg,   bits_next;
    logic [PERIOD_W-1:0]      tick_reg,   tick_next;
    logic                     line_reg,   line_next;
    logic                     valid_reg,  valid_next;
    out_t                     res_reg,    res_next;

    logic [PERIOD_W-1:0]      period;
    logic [PERIOD_W-1:0]      tick_inc;
    logic [WLEN_W-1:0]        eff_len;
    logic                     refused;
    logic                     pop;

    assign op_ready  = !valid_reg || res_ready;
    assign pop       = op_valid && op_ready;
    assign res_valid = valid_reg;
    assign res       = res_reg;

    assign period   = (bit_period_reg == '0) ? PERIOD_W'(1) : bit_period_reg;
    assign tick_inc = tick_reg + PERIOD_W'(1);

    always_comb begin
        if (word_length_reg < WLEN_W'(MIN_WORD_BITS)) begin
            eff_len = WLEN_W'(MIN_WORD_BITS);
        end else if (word_length_reg > WLEN_W'(MAX_WORD_BITS)) begin
            eff_len = WLEN_W'(MAX_WORD_BITS);
        end else begin
            eff_len = word_length_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_period_reg  <= BIT_PERIOD_RST;
            word_length_reg <= WORD_LENGTH_RST;
            two_stop_reg    <= TWO_STOP_BITS_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_BIT_PERIOD:    bit_period_reg  <= cfg_wdata[PERIOD_W-1:0];
                REG_WORD_LENGTH:   word_length_reg <= cfg_wdata[WLEN_W-1:0];
                REG_TWO_STOP_BITS: two_stop_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        phase_next = phase_reg;
        shift_next = shift_reg;
        bits_next  = bits_reg;
        tick_next  = tick_reg;
        line_next  = line_reg;
        refused    = 1'b0;

        if (op.kind == OP_OFFER) begin
            if (phase_reg == PH_IDLE) begin
                shift_next = op.word;
                phase_next = PH_START;
                tick_next  = '0;
                bits_next  = '0;
                line_next  = 1'b0;
            end else begin
                refused = 1'b1;
            end
        end else if (phase_reg != PH_IDLE) begin
            if (tick_inc >= period) begin
                tick_next = '0;
                unique case (phase_reg)
                    PH_START: begin
                        phase_next = PH_DATA;
                        bits_next  = eff_len - WLEN_W'(1);
                        line_next  = shift_reg[0];
                        shift_next = shift_reg >> 1;
                    end
                    PH_DATA: begin
                        if (bits_reg != '0) begin
                            bits_next  = bits_reg - WLEN_W'(1);
                            line_next  = shift_reg[0];
                            shift_next = shift_reg >> 1;
                        end else begin
                            phase_next = PH_STOP;
                            line_next  = 1'b1;
                            bits_next  = {{(WLEN_W-1){1'b0}}, two_stop_reg};
                        end
                    end
                    PH_STOP: begin
                        if (bits_reg != '0) begin
                            bits_next = bits_reg - WLEN_W'(1);
                        end else begin
                            phase_next = PH_IDLE;
                            line_next  = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end else begin
                tick_next = tick_inc;
            end
        end

        res_next.line_level = line_next;
        res_next.busy_res   = phase_next != PH_IDLE;
        res_next.refused    = refused;

        if (pop) begin
            valid_next = 1'b1;
        end else if (res_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            shift_reg <= '0;
            bits_reg  <= '0;
            tick_reg  <= '0;
            line_reg  <= 1'b1;
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (pop) begin
                phase_reg <= phase_next;
                shift_reg <= shift_next;
                bits_reg  <= bits_next;
                tick_reg  <= tick_next;
                line_reg  <= line_next;
                res_reg   <= res_next;
            end
        end
    end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    import uartx_pkg::*;

    typedef enum logic [1:0] {
        TX_IDLE,
        TX_START,
        TX_DATA,
        TX_STOP
    } tx_phase_t;

    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned ITEM_TARGET = 1900;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_t                   s_payload = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_t                  m_payload;

    uart_serial_transmitter_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #1 aclk = ~aclk;

    // transmitter shadow state and registers
    logic [PERIOD_W-1:0]      cfg_period   = BIT_PERIOD_RST;
    logic [WLEN_W-1:0]        cfg_wlen     = WORD_LENGTH_RST;
    logic                     cfg_two_stop = TWO_STOP_BITS_RST;
    tx_phase_t                phase_q      = TX_IDLE;
    logic [MAX_WORD_BITS-1:0] shreg        = '0;
    logic [3:0]               bits_left    = '0;
    logic [PERIOD_W-1:0]      tick_cnt     = '0;
    logic                     line_q       = 1'b1;

    out_t pending_levels[$];

    int unsigned n_sent    = 0;
    int unsigned n_checked = 0;
    int unsigned n_frames  = 0;
    int unsigned n_refused = 0;
    int unsigned n_err     = 0;
    int unsigned idle_cnt  = 0;

    function automatic out_t next_line_state(in_t it);
        out_t                r;
        logic [PERIOD_W-1:0] per;
        logic [PERIOD_W:0]   cnt;
        logic [3:0]          wl;
        r.refused = 1'b0;
        if (it.cmd == CMD_OFFER) begin
            if (phase_q == TX_IDLE) begin
                shreg     = it.word;
                phase_q   = TX_START;
                tick_cnt  = '0;
                bits_left = '0;
                line_q    = 1'b0;
            end else begin
                r.refused = 1'b1;
            end
        end else if (phase_q != TX_IDLE) begin
            per = (cfg_period == '0) ? 16'd1 : cfg_period;
            cnt = {1'b0, tick_cnt} + 17'd1;
            if (cnt >= {1'b0, per}) begin
                tick_cnt = '0;
                case (phase_q)
                    TX_START: begin
                        wl = cfg_wlen;
                        if (cfg_wlen < MIN_WORD_BITS) wl = WLEN_W'(MIN_WORD_BITS);
                        else if (cfg_wlen > MAX_WORD_BITS) wl = WLEN_W'(MAX_WORD_BITS);
                        phase_q   = TX_DATA;
                        bits_left = wl - 4'd1;
                        line_q    = shreg[0];
                        shreg     = shreg >> 1;
                    end
                    TX_DATA: begin
                        if (bits_left != '0) begin
                            bits_left = bits_left - 4'd1;
                            line_q    = shreg[0];
                            shreg     = shreg >> 1;
                        end else begin
                            phase_q   = TX_STOP;
                            line_q    = 1'b1;
                            bits_left = cfg_two_stop ? 4'd1 : 4'd0;
                        end
                    end
                    TX_STOP: begin
                        if (bits_left != '0) begin
                            bits_left = bits_left - 4'd1;
                        end else begin
                            phase_q = TX_IDLE;
                            line_q  = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end else begin
                tick_cnt = cnt[PERIOD_W-1:0];
            end
        end
        r.line_level = line_q;
        r.busy_res   = (phase_q != TX_IDLE);
        return r;
    endfunction

    function automatic in_t make_item(logic cmd, logic [MAX_WORD_BITS-1:0] w);
        in_t it;
        it.cmd  = cmd;
        it.word = w;
        return it;
    endfunction

    // mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch: %s", msg);
        n_err++;
    endtask

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(in_t it, int gap);
        out_t r;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        r = next_line_state(it);
        pending_levels.push_back(r);
        n_sent++;
        if (it.cmd == CMD_OFFER) begin
            if (r.refused) n_refused++;
            else n_frames++;
        end
        @(negedge aclk);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_levels.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_BIT_PERIOD:    cfg_period   = val;
            REG_WORD_LENGTH:   cfg_wlen     = val[WLEN_W-1:0];
            REG_TWO_STOP_BITS: cfg_two_stop = val[0];
            default: begin
            end
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic run_until_idle(bit gaps);
        while (phase_q != TX_IDLE)
            send_item(make_item(CMD_TICK, MAX_WORD_BITS'($urandom_range(0, 511))),
                      gaps ? pick_gap() : 0);
    endtask

    task automatic test_idle_and_refusal();
        send_item(make_item(CMD_TICK, 9'h1FF), 0);
        send_item(make_item(CMD_OFFER, 9'h1FF), 0);
        send_item(make_item(CMD_OFFER, 9'h000), 0);
        repeat (3) send_item(make_item(CMD_TICK, 9'h000), pick_gap());
        settle();
    endtask

    // frame in flight from the reset setup; registers change under it
    task automatic test_period_extremes();
        write_reg(REG_BIT_PERIOD, 16'hFFFF);
        repeat (3) send_item(make_item(CMD_TICK, 9'h1FF), 0);
        settle();
        write_reg(REG_WORD_LENGTH, 16'h000F);
        write_reg(REG_TWO_STOP_BITS, 16'h0001);
        write_reg(REG_BIT_PERIOD, 16'h0000);
        run_until_idle(1'b0);
        send_item(make_item(CMD_TICK, 9'h1FF), 0);
        settle();
    endtask

    task automatic test_word_length_clamp();
        write_reg(REG_WORD_LENGTH, 16'h0000);
        write_reg(REG_TWO_STOP_BITS, 16'h0000);
        write_reg(REG_UNUSED, 16'hFFFF);
        send_item(make_item(CMD_OFFER, 9'h155), 0);
        run_until_idle(1'b1);
        settle();
        write_reg(REG_WORD_LENGTH, 16'd9);
        write_reg(REG_BIT_PERIOD, 16'd1);
        send_item(make_item(CMD_OFFER, 9'h0AA), 0);
        send_item(make_item(CMD_TICK, 9'h000), 0);
        send_item(make_item(CMD_OFFER, 9'h1FF), 0);
        run_until_idle(1'b0);
        settle();
    endtask

    task automatic test_random_frames();
        int  n_items;
        int  r;
        bit  no_gaps;
        bit  is_offer;
        while (n_sent < ITEM_TARGET) begin
            settle();
            if ($urandom_range(0, 9) < 6) begin
                r = $urandom_range(0, 99);
                if (r < 70) write_reg(REG_BIT_PERIOD, CFG_DATA_W'($urandom_range(0, 3)));
                else if (r < 95) write_reg(REG_BIT_PERIOD, CFG_DATA_W'($urandom_range(4, 8)));
                else write_reg(REG_BIT_PERIOD, CFG_DATA_W'($urandom_range(9, 20)));
            end
            if ($urandom_range(0, 9) < 6)
                write_reg(REG_WORD_LENGTH, CFG_DATA_W'($urandom_range(0, 15)));
            if ($urandom_range(0, 9) < 5)
                write_reg(REG_TWO_STOP_BITS, CFG_DATA_W'($urandom_range(0, 1)));
            if ($urandom_range(0, 9) == 0)
                write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
            no_gaps = ($urandom_range(0, 3) == 0);
            n_items = $urandom_range(30, 90);
            repeat (n_items) begin
                if ($urandom_range(0, 99) < 2) settle();
                if (phase_q == TX_IDLE) is_offer = ($urandom_range(0, 99) < 85);
                else is_offer = ($urandom_range(0, 99) < 4);
                send_item(make_item(is_offer ? CMD_OFFER : CMD_TICK,
                                    MAX_WORD_BITS'($urandom_range(0, 511))),
                          no_gaps ? 0 : pick_gap());
            end
        end
        settle();
    endtask

    // result checker
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_levels.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing pending", n_checked));
            end else begin
                want = pending_levels.pop_front();
                if (m_payload.line_level !== want.line_level)
                    report_mismatch($sformatf("result %0d line_level %b, want %b",
                                              n_checked, m_payload.line_level, want.line_level));
                if (m_payload.busy_res !== want.busy_res)
                    report_mismatch($sformatf("result %0d busy_res %b, want %b",
                                              n_checked, m_payload.busy_res, want.busy_res));
                if (m_payload.refused !== want.refused)
                    report_mismatch($sformatf("result %0d refused %b, want %b",
                                              n_checked, m_payload.refused, want.refused));
            end
            n_checked++;
        end
    end

    // result side back-pressure
    initial begin : result_sink
        bit stalling;
        int left;
        stalling = 1'b1;
        left     = 0;
        forever begin
            @(negedge aclk);
            if (left == 0) begin
                stalling = !stalling;
                if (stalling) left = pick_gap();
                else if ($urandom_range(0, 9) == 0) left = $urandom_range(100, 300);
                else left = $urandom_range(1, 8);
                if (stalling && left == 0) begin
                    stalling = 1'b0;
                    left     = $urandom_range(1, 8);
                end
            end
            m_ready <= !stalling;
            left--;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cnt = 0;
            else idle_cnt++;
            if (idle_cnt >= STALL_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_idle_and_refusal();
        test_period_extremes();
        test_word_length_clamp();
        test_random_frames();
        repeat (12) @(posedge aclk);
        $display("%0d transfers in, %0d results checked, %0d frames started, %0d offers refused",
                 n_sent, n_checked, n_frames, n_refused);
        $display("covered word lengths 0..15, periods 0 to 65535, both stop modes, mid-frame writes");
        if (n_err == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
